/* hw/rtl/ppid_pkg.sv */
// ----------------------------------------------------------------------------
// ppid_pkg: shared types and constants for the positional PID block
// Register indexes, field widths, reset values and the payload structs that
// travel between the pipeline stages.
// ----------------------------------------------------------------------------
package ppid_pkg;

	localparam int FRAC_BITS = 8;
	localparam int IN_W      = 16;
	localparam int ERR_W     = 17;
	localparam int DERR_W    = 18;
	localparam int INTEG_W   = 32;
	localparam int GAIN_W    = 24;
	localparam int ENC_GAIN_W = 8;
	localparam int ENC_LIM_W = 15;
	localparam int MAG_W     = 10;
	localparam int DRIVE_W   = 11;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 24;

	localparam int P_PROD_W = GAIN_W + ERR_W;
	localparam int I_PROD_W = GAIN_W + INTEG_W;
	localparam int D_PROD_W = GAIN_W + DERR_W;
	localparam int E_PROD_W = IN_W + ENC_GAIN_W + 1;
	localparam int ACC_W    = 58;

	// Register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN       = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ENCODER_GAIN    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ENCODER_LIMIT   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_DEADBAND_OFFSET = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_CLAMP_THRESHOLD = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_CLAMP_VALUE     = 3'd7;

	// Reset values
	localparam logic signed [GAIN_W-1:0]  RST_PROP_GAIN       = 24'sd20480;
	localparam logic signed [GAIN_W-1:0]  RST_INTEG_GAIN      = 24'sd0;
	localparam logic signed [GAIN_W-1:0]  RST_DERIV_GAIN      = 24'sd64000;
	localparam logic [ENC_GAIN_W-1:0]     RST_ENCODER_GAIN    = 8'd15;
	localparam logic [ENC_LIM_W-1:0]      RST_ENCODER_LIMIT   = 15'd30;
	localparam logic [MAG_W-1:0]          RST_DEADBAND_OFFSET = 10'd80;
	localparam logic [MAG_W-1:0]          RST_CLAMP_THRESHOLD = 10'd400;
	localparam logic [MAG_W-1:0]          RST_CLAMP_VALUE     = 10'd850;

	typedef struct packed {
		logic signed [GAIN_W-1:0] prop_gain;
		logic signed [GAIN_W-1:0] integ_gain;
		logic signed [GAIN_W-1:0] deriv_gain;
		logic [ENC_GAIN_W-1:0]    encoder_gain;
		logic [ENC_LIM_W-1:0]     encoder_limit;
		logic [MAG_W-1:0]         deadband_offset;
		logic [MAG_W-1:0]         clamp_threshold;
		logic [MAG_W-1:0]         clamp_value;
	} cfg_t;

	typedef struct packed {
		logic signed [IN_W-1:0] measured;
		logic signed [IN_W-1:0] setpoint;
		logic signed [IN_W-1:0] encoder_count;
	} sample_t;

	typedef struct packed {
		logic signed [ERR_W-1:0]   err;
		logic signed [INTEG_W-1:0] isum;
		logic signed [DERR_W-1:0]  derr;
		logic signed [IN_W-1:0]    enc;
	} terms_t;

	typedef struct packed {
		logic signed [P_PROD_W-1:0] p_prod;
		logic signed [I_PROD_W-1:0] i_prod;
		logic signed [D_PROD_W-1:0] d_prod;
		logic signed [E_PROD_W-1:0] e_prod;
	} prods_t;

endpackage

/* hw/rtl/positional_pid_with_deadband_top.sv */
// ----------------------------------------------------------------------------
// positional_pid_with_deadband_top: positional PID with dead zone and clamp
// One drive word per sample word: PID terms with Q16.8 gains, encoder
// feedforward, dead-zone offset and output clamp.
// ----------------------------------------------------------------------------
//  channel   direction  contents
//  s_axis    in         sample word: measured, setpoint, encoder_count
//  m_axis    out        drive word: drive
//  cfg       in         register writes, index 0..7, no read-back
//
// Each word passes five register stages (input, error terms, products, sum,
// output) on its way from the sample word to the drive word.
// One sample word can be taken every cycle while m_axis takes drive words; the rate is set by the stage
// handshake, with each stage free to load when it is empty or moving on.
// A stalled m_axis holds the output and backs up the stages one by one.
// Reset clears the valid bits, the integral and the previous error, and
// loads the default register values.
// ----------------------------------------------------------------------------
module positional_pid_with_deadband_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// [15:0] measured, [31:16] setpoint, [47:32] encoder_count
	input  logic [47:0]                       s_axis_tdata,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// [10:0] drive, [15:11] zero
	output logic [15:0]                       m_axis_tdata,
	input  logic                              cfg_we,
	input  logic [ppid_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [ppid_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
	import ppid_pkg::*;

	cfg_t                      cfg;
	sample_t                   sample;
	logic                      terms_valid;
	logic                      terms_ready;
	terms_t                    terms;
	logic                      prods_valid;
	logic                      prods_ready;
	prods_t                    prods;
	logic signed [DRIVE_W-1:0] drive;

	assign sample.measured      = $signed(s_axis_tdata[15:0]);
	assign sample.setpoint      = $signed(s_axis_tdata[31:16]);
	assign sample.encoder_count = $signed(s_axis_tdata[47:32]);

	ppid_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	ppid_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_data   (sample),
		.out_valid (terms_valid),
		.out_ready (terms_ready),
		.out_data  (terms)
	);

	ppid_mult u_mult (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (terms_valid),
		.in_ready  (terms_ready),
		.in_data   (terms),
		.out_valid (prods_valid),
		.out_ready (prods_ready),
		.out_data  (prods)
	);

	ppid_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (prods_valid),
		.in_ready  (prods_ready),
		.in_data   (prods),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.drive     (drive)
	);

	assign m_axis_tdata = {5'b0, drive};

endmodule

/* hw/rtl/ppid_cfg.sv */
// ----------------------------------------------------------------------------
// ppid_cfg: configuration registers
// Holds the gains, limits and output shaping values written over the plain
// write port.
// ----------------------------------------------------------------------------
module ppid_cfg (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [ppid_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [ppid_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	output ppid_pkg::cfg_t                     cfg
);
	import ppid_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.prop_gain       <= RST_PROP_GAIN;
			cfg_q.integ_gain      <= RST_INTEG_GAIN;
			cfg_q.deriv_gain      <= RST_DERIV_GAIN;
			cfg_q.encoder_gain    <= RST_ENCODER_GAIN;
			cfg_q.encoder_limit   <= RST_ENCODER_LIMIT;
			cfg_q.deadband_offset <= RST_DEADBAND_OFFSET;
			cfg_q.clamp_threshold <= RST_CLAMP_THRESHOLD;
			cfg_q.clamp_value     <= RST_CLAMP_VALUE;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PROP_GAIN:       cfg_q.prop_gain       <= $signed(cfg_wdata[GAIN_W-1:0]);
				REG_INTEG_GAIN:      cfg_q.integ_gain      <= $signed(cfg_wdata[GAIN_W-1:0]);
				REG_DERIV_GAIN:      cfg_q.deriv_gain      <= $signed(cfg_wdata[GAIN_W-1:0]);
				REG_ENCODER_GAIN:    cfg_q.encoder_gain    <= cfg_wdata[ENC_GAIN_W-1:0];
				REG_ENCODER_LIMIT:   cfg_q.encoder_limit   <= cfg_wdata[ENC_LIM_W-1:0];
				REG_DEADBAND_OFFSET: cfg_q.deadband_offset <= cfg_wdata[MAG_W-1:0];
				REG_CLAMP_THRESHOLD: cfg_q.clamp_threshold <= cfg_wdata[MAG_W-1:0];
				REG_CLAMP_VALUE:     cfg_q.clamp_value     <= cfg_wdata[MAG_W-1:0];
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* hw/rtl/ppid_front.sv */
// ----------------------------------------------------------------------------
// ppid_front: input register and error terms
// Registers the incoming sample, then forms the error, the saturated integral,
// the error difference and the clamped encoder count, and updates the loop
// state once per sample.
// ----------------------------------------------------------------------------
module ppid_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ppid_pkg::cfg_t        cfg,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  ppid_pkg::sample_t     in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output ppid_pkg::terms_t      out_data
);
	import ppid_pkg::*;

	logic                       valid_s1;
	sample_t                    data_s1;
	logic                       valid_s2;
	terms_t                     data_s2;
	logic                       ready_s2;
	logic                       load_s2;
	logic signed [INTEG_W-1:0]  integral_q;
	logic signed [ERR_W-1:0]    prev_err_q;
	logic signed [ERR_W-1:0]    err;
	logic signed [INTEG_W:0]    isum_wide;
	logic signed [INTEG_W-1:0]  isum;
	logic signed [IN_W-1:0]     lim;
	logic signed [IN_W-1:0]     enc_clamped;
	terms_t                     terms;

	assign ready_s2 = !valid_s2 || out_ready;
	assign in_ready = !valid_s1 || ready_s2;
	assign load_s2  = valid_s1 && ready_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1 <= in_data;
		end
	end

	always_comb begin
		err       = ERR_W'(data_s1.setpoint) - ERR_W'(data_s1.measured);
		isum_wide = (INTEG_W+1)'(integral_q) + (INTEG_W+1)'(err);
		// Saturate when the 33-bit sum leaves the 32-bit range.
		if (isum_wide[INTEG_W] != isum_wide[INTEG_W-1]) begin
			isum = isum_wide[INTEG_W] ? {1'b1, {(INTEG_W-1){1'b0}}}
			                          : {1'b0, {(INTEG_W-1){1'b1}}};
		end else begin
			isum = isum_wide[INTEG_W-1:0];
		end
		lim = $signed({1'b0, cfg.encoder_limit});
		priority if (data_s1.encoder_count > lim) begin
			enc_clamped = lim;
		end else if (data_s1.encoder_count < -lim) begin
			enc_clamped = -lim;
		end else begin
			enc_clamped = data_s1.encoder_count;
		end
		terms.err  = err;
		terms.isum = isum;
		terms.derr = DERR_W'(err) - DERR_W'(prev_err_q);
		terms.enc  = enc_clamped;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2   <= 1'b0;
			integral_q <= '0;
			prev_err_q <= '0;
		end else begin
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
			if (load_s2) begin
				integral_q <= isum;
				prev_err_q <= err;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_s2) begin
			data_s2 <= terms;
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = data_s2;

endmodule

/* hw/rtl/ppid_mult.sv */
// ----------------------------------------------------------------------------
// ppid_mult: gain products
// Multiplies the error, integral, error difference and clamped encoder count
// by their gains, one registered product each.
// ----------------------------------------------------------------------------
module ppid_mult (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ppid_pkg::cfg_t        cfg,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  ppid_pkg::terms_t      in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output ppid_pkg::prods_t      out_data
);
	import ppid_pkg::*;

	logic    valid_s3;
	prods_t  data_s3;
	prods_t  prods;

	assign in_ready = !valid_s3 || out_ready;

	always_comb begin
		prods.p_prod = $signed(cfg.prop_gain) * $signed(in_data.err);
		prods.i_prod = $signed(cfg.integ_gain) * $signed(in_data.isum);
		prods.d_prod = $signed(cfg.deriv_gain) * $signed(in_data.derr);
		prods.e_prod = $signed(in_data.enc) * $signed({1'b0, cfg.encoder_gain});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (in_ready) begin
			valid_s3 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s3 <= prods;
		end
	end

	assign out_valid = valid_s3;
	assign out_data  = data_s3;

endmodule

/* hw/rtl/ppid_out.sv */
// ----------------------------------------------------------------------------
// ppid_out: sum and output shaping
// Adds the products in Q.8, then applies the dead-zone offset, the threshold
// clamp and truncation toward zero into the output register.
// ----------------------------------------------------------------------------
module ppid_out (
	input  logic                             clk,
	input  logic                             arst_n,
	input  ppid_pkg::cfg_t                   cfg,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  ppid_pkg::prods_t                 in_data,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic signed [ppid_pkg::DRIVE_W-1:0] drive
);
	import ppid_pkg::*;

	logic                      valid_s4;
	logic signed [ACC_W-1:0]   acc_s4;
	logic                      ready_s4;
	logic                      valid_s5;
	logic signed [DRIVE_W-1:0] drive_s5;
	logic signed [ACC_W-1:0]   sum;
	logic signed [ACC_W-1:0]   offs;
	logic signed [ACC_W-1:0]   thr;
	logic signed [ACC_W-1:0]   shaped;
	logic signed [ACC_W-1:0]   trunc;
	logic signed [DRIVE_W-1:0] res;

	assign ready_s4 = !valid_s5 || out_ready;
	assign in_ready = !valid_s4 || ready_s4;

	always_comb begin
		sum = ACC_W'(in_data.p_prod) + ACC_W'(in_data.i_prod) + ACC_W'(in_data.d_prod)
		    + (ACC_W'(in_data.e_prod) <<< FRAC_BITS);
	end

	always_comb begin
		offs = $signed({{(ACC_W-MAG_W-FRAC_BITS){1'b0}}, cfg.deadband_offset,
		                {FRAC_BITS{1'b0}}});
		thr  = $signed({{(ACC_W-MAG_W-FRAC_BITS){1'b0}}, cfg.clamp_threshold,
		                {FRAC_BITS{1'b0}}});
		// A drive of exactly zero gets no offset.
		priority if (acc_s4 > 0) begin
			shaped = acc_s4 + offs;
		end else if (acc_s4 < 0) begin
			shaped = acc_s4 - offs;
		end else begin
			shaped = '0;
		end
		// Bias negative values so the arithmetic shift truncates toward zero.
		trunc = (shaped + (shaped[ACC_W-1] ? ACC_W'((1 << FRAC_BITS) - 1) : '0))
		        >>> FRAC_BITS;
		priority if (shaped > thr) begin
			res = $signed({1'b0, cfg.clamp_value});
		end else if (shaped < -thr) begin
			res = -$signed({1'b0, cfg.clamp_value});
		end else begin
			res = trunc[DRIVE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s4 <= in_valid;
			end
			if (ready_s4) begin
				valid_s5 <= valid_s4;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			acc_s4 <= sum;
		end
		if (ready_s4 && valid_s4) begin
			drive_s5 <= res;
		end
	end

	assign out_valid = valid_s5;
	assign drive     = drive_s5;

endmodule

/* hw/rtl/ppid_chk.sv */
// ----------------------------------------------------------------------------
// ppid_chk: port checker for the positional PID block
// Watches the stream ports and flags handshake and output range errors.
// ----------------------------------------------------------------------------
module ppid_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [15:0] m_axis_tdata
);

	// A held output word must not change until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output word changed while stalled");

	// With no output waiting every stage can load, so the input must be open.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input blocked while output is empty");

	// Drive stays within plus or minus 1023 and the pad bits stay clear.
	a_drive_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[15:11] == 5'b0 && m_axis_tdata[10:0] != 11'h400)
		else $error("drive word out of range");

	// A taken input word is never lost when the output side keeps draining.
	a_input_reaches_stage: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && m_axis_tready ##1 m_axis_tready ##1 m_axis_tready
		##1 m_axis_tready ##1 m_axis_tready |=> m_axis_tvalid)
		else $error("accepted word did not reach the output");

endmodule

bind positional_pid_with_deadband_top ppid_chk u_ppid_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

/* tb/sv/ppid_drive_checker.sv */
// ----------------------------------------------------------------------------
// ppid_drive_checker: drive predictor and scoreboard for the positional PID
// Watches the register port and both stream channels, keeps its own copy of
// the gains, the integral and the previous error, predicts one drive word
// per accepted sample word and compares each accepted drive word with the
// oldest prediction.
// ----------------------------------------------------------------------------
module ppid_drive_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	input  logic                            s_axis_tready,
	// [15:0] measured, [31:16] setpoint, [47:32] encoder_count
	input  logic [47:0]                     s_axis_tdata,
	input  logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// [10:0] drive, [15:11] zero
	input  logic [15:0]                     m_axis_tdata,
	input  logic                            cfg_we,
	input  logic [ppid_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ppid_pkg::CFG_DATA_W-1:0] cfg_wdata,
	output int                              fail_count,
	output int                              outstanding
);
	import ppid_pkg::*;

	localparam longint ONE_Q = longint'(1) << FRAC_BITS;

	cfg_t                      gains;
	logic signed [INTEG_W-1:0] integ_acc;
	logic signed [ERR_W-1:0]   last_err;
	logic [15:0]               drive_q[$];
	int                        mismatches = 0;

	// Advances the controller state by one sample and returns the drive.
	function automatic logic [DRIVE_W-1:0] next_drive(input sample_t smp);
		longint err, isum, enc, lim, acc, thr, res;
		err  = longint'(smp.setpoint) - longint'(smp.measured);
		isum = longint'(integ_acc) + err;
		if (isum > longint'(32'sh7fff_ffff))
			isum = longint'(32'sh7fff_ffff);
		if (isum < -longint'(32'sh7fff_ffff) - 1)
			isum = -longint'(32'sh7fff_ffff) - 1;
		integ_acc = isum[INTEG_W-1:0];

		lim = longint'(gains.encoder_limit);
		enc = longint'(smp.encoder_count);
		if (enc > lim)
			enc = lim;
		if (enc < -lim)
			enc = -lim;

		acc = longint'(gains.prop_gain) * err
			+ longint'(gains.integ_gain) * isum
			+ longint'(gains.deriv_gain) * (err - longint'(last_err))
			+ enc * longint'(gains.encoder_gain) * ONE_Q;
		last_err = err[ERR_W-1:0];

		// The dead-zone offset follows the sign; exactly zero stays zero.
		if (acc > 0)
			acc = acc + longint'(gains.deadband_offset) * ONE_Q;
		else if (acc < 0)
			acc = acc - longint'(gains.deadband_offset) * ONE_Q;

		thr = longint'(gains.clamp_threshold) * ONE_Q;
		if (acc > thr)
			res = longint'(gains.clamp_value);
		else if (acc < -thr)
			res = -longint'(gains.clamp_value);
		else
			res = acc / ONE_Q;
		return res[DRIVE_W-1:0];
	endfunction

	always @(posedge clk) begin
		sample_t     smp;
		logic [15:0] exp_word;
		if (!arst_n) begin
			gains.prop_gain       = RST_PROP_GAIN;
			gains.integ_gain      = RST_INTEG_GAIN;
			gains.deriv_gain      = RST_DERIV_GAIN;
			gains.encoder_gain    = RST_ENCODER_GAIN;
			gains.encoder_limit   = RST_ENCODER_LIMIT;
			gains.deadband_offset = RST_DEADBAND_OFFSET;
			gains.clamp_threshold = RST_CLAMP_THRESHOLD;
			gains.clamp_value     = RST_CLAMP_VALUE;
			integ_acc = '0;
			last_err  = '0;
			drive_q.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_PROP_GAIN:       gains.prop_gain       = cfg_wdata;
					REG_INTEG_GAIN:      gains.integ_gain      = cfg_wdata;
					REG_DERIV_GAIN:      gains.deriv_gain      = cfg_wdata;
					REG_ENCODER_GAIN:    gains.encoder_gain    = cfg_wdata[ENC_GAIN_W-1:0];
					REG_ENCODER_LIMIT:   gains.encoder_limit   = cfg_wdata[ENC_LIM_W-1:0];
					REG_DEADBAND_OFFSET: gains.deadband_offset = cfg_wdata[MAG_W-1:0];
					REG_CLAMP_THRESHOLD: gains.clamp_threshold = cfg_wdata[MAG_W-1:0];
					REG_CLAMP_VALUE:     gains.clamp_value     = cfg_wdata[MAG_W-1:0];
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready) begin
				smp.measured      = s_axis_tdata[15:0];
				smp.setpoint      = s_axis_tdata[31:16];
				smp.encoder_count = s_axis_tdata[47:32];
				drive_q.push_back({5'b0, next_drive(smp)});
			end
			if (m_axis_tvalid && m_axis_tready) begin
				if (drive_q.size() == 0) begin
					$display("%0t: drive word with no sample waiting, expected none, got %0d (0x%h)",
						$time, $signed(m_axis_tdata[DRIVE_W-1:0]), m_axis_tdata);
					mismatches++;
				end else begin
					exp_word = drive_q.pop_front();
					if (m_axis_tdata !== exp_word) begin
						$display("%0t: drive mismatch, expected %0d (0x%h), got %0d (0x%h)",
							$time, $signed(exp_word[DRIVE_W-1:0]), exp_word,
							$signed(m_axis_tdata[DRIVE_W-1:0]), m_axis_tdata);
						mismatches++;
					end
				end
			end
		end
		fail_count  <= mismatches;
		outstanding <= drive_q.size();
	end

endmodule

/* tb/sv/tb_positional_pid_with_deadband_top.sv */
// ----------------------------------------------------------------------------
// tb_positional_pid_with_deadband_top: testbench for the positional PID block
// Drives sample words in random bursts under a stalling receiver, walks the
// registers through directed and random settings (extremes included), winds
// the integral up and back down through zero and leaves all checking to the
// drive checker beside the block.
// ----------------------------------------------------------------------------
module tb_positional_pid_with_deadband_top;
	import ppid_pkg::*;

	localparam int HALF_PERIOD = 4;

	typedef enum int {STALL_NONE, STALL_RANDOM, STALL_PERIODIC} stall_mode_e;

	logic                  clk           = 1'b0;
	logic                  arst_n        = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [47:0]           s_axis_tdata  = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [15:0]           m_axis_tdata;
	logic                  cfg_we        = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index     = REG_PROP_GAIN;
	logic [CFG_DATA_W-1:0] cfg_wdata     = '0;
	int                    fail_count;
	int                    outstanding;

	stall_mode_e stall_mode = STALL_NONE;
	int          tick       = 0;
	int          burst_left = 0;
	int          gap_max    = 0;

	positional_pid_with_deadband_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata)
	);

	ppid_drive_checker checker_i (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.fail_count    (fail_count),
		.outstanding   (outstanding)
	);

	always #(HALF_PERIOD) clk = ~clk;

	// Drive word receiver with its own stall pattern.
	always @(posedge clk) begin
		tick <= tick + 1;
		case (stall_mode)
			STALL_NONE:   m_axis_tready <= 1'b1;
			STALL_RANDOM: m_axis_tready <= ($urandom_range(0, 2) != 0);
			default:      m_axis_tready <= ((tick % 11) < 7);
		endcase
	end

	initial begin
		#(8_000_000);
		$display("CHECK FAILED");
		$finish;
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= CFG_DATA_W'(value);
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	task automatic load_regs(input int pg, input int ig, input int dg, input int eg,
			input int el, input int db, input int th, input int cv);
		write_reg(REG_PROP_GAIN, pg);
		write_reg(REG_INTEG_GAIN, ig);
		write_reg(REG_DERIV_GAIN, dg);
		write_reg(REG_ENCODER_GAIN, eg);
		write_reg(REG_ENCODER_LIMIT, el);
		write_reg(REG_DEADBAND_OFFSET, db);
		write_reg(REG_CLAMP_THRESHOLD, th);
		write_reg(REG_CLAMP_VALUE, cv);
	endtask

	task automatic set_pace(input stall_mode_e sm, input int gm);
		stall_mode <= sm;
		gap_max    = gm;
		burst_left = 0;
	endtask

	// Presents one sample word and returns once it has been taken. The valid
	// only drops at the end of a burst, and then only when a gap length is set.
	task automatic send_sample(input int meas, input int setp, input int enc);
		s_axis_tdata  <= {16'(enc), 16'(setp), 16'(meas)};
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		if (burst_left > 0)
			burst_left--;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			if (gap_max > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat ($urandom_range(1, gap_max)) @(posedge clk);
			end
		end
	endtask

	// Waits until every predicted drive word has come out.
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	function automatic int rand_s16();
		return int'($signed(16'($urandom)));
	endfunction

	function automatic int pick_gain();
		case ($urandom_range(0, 7))
			0: return -8388608;
			1: return 8388607;
			2: return 0;
			3, 4, 5: return int'($urandom_range(0, 1024)) - 512;
			default: return int'($urandom_range(0, 65536)) - 32768;
		endcase
	endfunction

	function automatic int pick_field(input int top);
		case ($urandom_range(0, 5))
			0: return 0;
			1: return top;
			default: return int'($urandom_range(0, top));
		endcase
	endfunction

	task automatic send_random_sample();
		int meas, setp, enc;
		int corners[5] = '{-32768, -1, 0, 1, 32767};
		meas = rand_s16();
		setp = rand_s16();
		enc  = rand_s16();
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: begin
				// Small errors keep the drive out of the clamp most of the time.
				setp = meas + int'($urandom_range(0, 64)) - 32;
				if (setp > 32767)
					setp = 32767;
				if (setp < -32768)
					setp = -32768;
				enc = int'($urandom_range(0, 128)) - 64;
			end
			8: begin
				meas = corners[$urandom_range(0, 4)];
				setp = corners[$urandom_range(0, 4)];
				enc  = corners[$urandom_range(0, 4)];
			end
			9: setp = meas;
			default: ;
		endcase
		send_sample(meas, setp, enc);
	endtask

	initial begin
		int gaps[3];
		gaps = '{0, 2, 8};
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Default registers: zero input and the widest errors and counts.
		set_pace(STALL_NONE, 0);
		send_sample(0, 0, 0);
		send_sample(-32768, 32767, 32767);
		send_sample(32767, -32768, -32768);
		send_sample(5, 6, -1);
		send_sample(0, 0, 0);
		drain();

		// Unit gain: errors right at and just past the threshold.
		set_pace(STALL_RANDOM, 3);
		load_regs(256, 0, 0, 0, 0, 0, 100, 1023);
		send_sample(0, 100, 0);
		send_sample(0, 101, 0);
		send_sample(100, 0, 0);
		send_sample(101, 0, 0);
		drain();

		// Smallest gain step: the threshold compare is exact in Q.8.
		load_regs(1, 0, 0, 0, 0, 0, 100, 1023);
		send_sample(0, 25600, 0);
		send_sample(0, 25601, 0);
		send_sample(25600, 0, 0);
		send_sample(25601, 0, 0);
		drain();

		// Half gain: fractions truncate toward zero.
		set_pace(STALL_PERIODIC, 0);
		load_regs(128, 0, 0, 0, 0, 0, 1023, 0);
		send_sample(3, 0, 0);
		send_sample(0, 1, 0);
		drain();

		// Dead-zone offset lands exactly on the widest threshold.
		load_regs(1, 0, 0, 0, 0, 1000, 1023, 0);
		send_sample(0, 5888, 0);
		send_sample(5888, 0, 0);
		send_sample(0, 5889, 0);
		drain();

		// Encoder feedforward alone, widest limit and gain.
		set_pace(STALL_RANDOM, 8);
		load_regs(0, 0, 0, 255, 32767, 0, 1023, 1023);
		send_sample(0, 0, -32768);
		send_sample(0, 0, 1);
		send_sample(0, 0, 4);
		send_sample(0, 0, -4);
		drain();

		// Extreme gains with a zero threshold and a zero encoder limit.
		load_regs(-8388608, 8388607, -8388608, 255, 0, 1023, 0, 1023);
		send_sample(0, 1, 100);
		send_sample(1, 0, -100);
		drain();

		// Integral wind-up with the widest positive errors and then twice as
		// many of the widest negative ones. With only the integral gain set,
		// the drive changes sign where the sum crosses zero.
		set_pace(STALL_RANDOM, 0);
		load_regs(0, 1, 0, 0, 0, 0, 1023, 1023);
		repeat (24) send_sample(-32768, 32767, rand_s16());
		repeat (48) send_sample(32767, -32768, rand_s16());
		repeat (40) send_random_sample();
		drain();

		for (int phase = 0; phase < 8; phase++) begin
			set_pace(stall_mode_e'($urandom_range(0, 2)), gaps[$urandom_range(0, 2)]);
			load_regs(pick_gain(), pick_gain(), pick_gain(), pick_field(255),
				pick_field(32767), pick_field(1023), pick_field(1023), pick_field(1023));
			repeat (90) send_random_sample();
			drain();
		end

		repeat (20) @(posedge clk);
		if (fail_count == 0 && outstanding == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

/* filelist.f */
hw/rtl/ppid_pkg.sv
hw/rtl/ppid_cfg.sv
hw/rtl/ppid_front.sv
hw/rtl/ppid_mult.sv
hw/rtl/ppid_out.sv
hw/rtl/positional_pid_with_deadband_top.sv
hw/rtl/ppid_chk.sv
tb/sv/ppid_drive_checker.sv
tb/sv/tb_positional_pid_with_deadband_top.sv
